/* sv/lztsd_pkg.sv */
// Shared types, constants and helpers for the LZ token stream decompressor.
// Used by lztsd_front, lztsd_queue, lztsd_back and lz_token_stream_decompressor.
// Has no dependencies.
package lztsd_pkg;

  // History window size in bytes; addresses and the fill counter follow from it.
  localparam int unsigned HISTORY_DEPTH = 65536;
  localparam int unsigned HIST_AW       = $clog2(HISTORY_DEPTH);
  localparam int unsigned FILL_W        = $clog2(HISTORY_DEPTH + 1);

  // Entries of the queue between the parser and the history back end.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ERR_W       = 3;
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_PULL = 1'b1;

  typedef logic [HIST_AW-1:0] hist_addr_t;
  typedef logic [FILL_W-1:0]  fill_count_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK         = 3'd0,
    ERR_PUSH_BUSY  = 3'd1,
    ERR_DISTANCE   = 3'd2,
    ERR_EMPTY_PULL = 3'd3,
    ERR_OVERFLOW   = 3'd4,
    ERR_TRUNCATED  = 3'd5
  } err_code_t;

  // One classified word handed from the parser to the back end.
  typedef struct packed {
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;      // literal byte, zero otherwise
    logic              is_copy;       // byte comes from history at raddr
    hist_addr_t        raddr;
    hist_addr_t        waddr;
    logic              copy_pending;
    err_code_t         error_code;
  } item_t;

  // Circular history index increment.
  function automatic hist_addr_t next_index(input hist_addr_t i);
    hist_addr_t r;
    if (i == hist_addr_t'(HISTORY_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + hist_addr_t'(1);
    end
    return r;
  endfunction

endpackage

/* sv/lz_token_stream_decompressor.sv */
// Top level of the LZ token stream decompressor: parser front end, decoupling
// queue and history back end. Depends on lztsd_pkg, lztsd_front, lztsd_queue, lztsd_back.
//
// Usage: each input word on the s_axis channel is a command. tuser = 0 pushes the
// compressed byte in tdata; tlast on a push marks the last byte of the stream,
// after which the parser and history restart. tuser = 1 pulls one byte of a
// pending match copy. Every input word produces exactly one output word on the
// m_axis channel carrying a byte flag, the byte, the copy-pending status and an
// error code.
// Throughput is one word per cycle in both directions while the receiver takes
// words: the parser classifies a word in the cycle it is accepted, and the back
// end reads and writes the history memory once per cycle, forwarding the byte
// still being written when a copy reads right behind it (distance one).
// An accepted word is written into the queue, then moves to the output register
// together with its history read.
// When the receiver stalls, the output register holds its word and the queue
// fills; s_axis_tready drops only when the four-entry queue is full.
// Reset clears the parser state, pointers, queue and output register; history
// contents are not cleared because a copy can only reach bytes already written.
module lz_token_stream_decompressor (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [lztsd_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [7:0] compressed_byte
  input  logic                                  s_axis_tuser,  // [0] command
  input  logic                                  s_axis_tlast,  // end_of_stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [0] byte_valid, [8:1] out_byte, [9] copy_pending, [12:10] error_code, [15:13] zero
  output logic [lztsd_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

  logic             push;
  lztsd_pkg::item_t push_item;
  logic             space;
  logic             head_valid;
  lztsd_pkg::item_t head_item;
  logic             pop;

  lztsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_command (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .space      (space),
    .push       (push),
    .push_item  (push_item)
  );

  lztsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .space      (space),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop)
  );

  lztsd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

endmodule

/* sv/lztsd_front.sv */
// Token parser front end: takes one command word per cycle while the queue has space,
// tracks the token state, pointers and counters, and emits one classified item per word.
// Depends on lztsd_pkg.
module lztsd_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_command,
  input  logic [lztsd_pkg::BYTE_W-1:0]          in_byte,
  input  logic                                  in_last,
  input  logic                                  space,
  output logic                                  push,
  output lztsd_pkg::item_t                      push_item
);

  typedef enum logic [2:0] {
    PH_TOKEN      = 3'd0,
    PH_LIT_HDR    = 3'd1,
    PH_LIT_DATA   = 3'd2,
    PH_MATCH_HDR  = 3'd3,
    PH_MATCH_DIST = 3'd4,
    PH_COPY       = 3'd5
  } phase_t;

  localparam int unsigned FW = lztsd_pkg::FIELD_W;
  localparam int unsigned FL = lztsd_pkg::FILL_W;

  phase_t                        phase, phase_next;
  logic [2:0]                    hdr_left, hdr_left_next;
  logic [2:0]                    dist_left, dist_left_next;
  logic [FW-1:0]                 len_count, len_count_next;
  logic [FW-1:0]                 dist_value, dist_value_next;
  lztsd_pkg::hist_addr_t         wr_ptr, wr_ptr_next;
  lztsd_pkg::fill_count_t        filled, filled_next;
  lztsd_pkg::hist_addr_t         copy_src, copy_src_next;
  logic                          ovf, ovf_next;
  logic                          restart_pend, restart_pend_next;

  logic                          fire;
  logic                          finish;
  logic [FL-1:0]                 wp_ext;
  logic [FL-1:0]                 dist_lo;
  logic [FL-1:0]                 src_calc;
  lztsd_pkg::err_code_t          err;

  assign in_ready = space;
  assign fire     = in_valid && space;
  assign push     = fire;

  assign wp_ext  = FL'(wr_ptr);

  always_comb begin
    phase_next        = phase;
    hdr_left_next     = hdr_left;
    dist_left_next    = dist_left;
    len_count_next    = len_count;
    dist_value_next   = dist_value;
    wr_ptr_next       = wr_ptr;
    filled_next       = filled;
    copy_src_next     = copy_src;
    ovf_next          = ovf;
    restart_pend_next = restart_pend;
    finish            = 1'b0;
    dist_lo           = '0;
    src_calc          = '0;
    err               = lztsd_pkg::ERR_OK;
    push_item         = '0;

    if (in_command == lztsd_pkg::CMD_PULL) begin
      if (phase != PH_COPY) begin
        err = lztsd_pkg::ERR_EMPTY_PULL;
      end else begin
        push_item.byte_valid = 1'b1;
        push_item.is_copy    = 1'b1;
        push_item.raddr      = copy_src;
        push_item.waddr      = wr_ptr;
        wr_ptr_next   = lztsd_pkg::next_index(wr_ptr);
        copy_src_next = lztsd_pkg::next_index(copy_src);
        if (filled != FL'(lztsd_pkg::HISTORY_DEPTH)) begin
          filled_next = filled + FL'(1);
        end
        len_count_next = len_count - FW'(1);
        if (len_count == FW'(1)) begin
          phase_next = PH_TOKEN;
          if (restart_pend) begin
            phase_next        = PH_TOKEN;
            hdr_left_next     = '0;
            dist_left_next    = '0;
            len_count_next    = '0;
            dist_value_next   = '0;
            wr_ptr_next       = '0;
            filled_next       = '0;
            copy_src_next     = '0;
            ovf_next          = 1'b0;
            restart_pend_next = 1'b0;
          end
        end
      end
    end else if (phase == PH_COPY) begin
      err = lztsd_pkg::ERR_PUSH_BUSY;
    end else begin
      unique case (phase)
        PH_TOKEN: begin
          len_count_next  = '0;
          dist_value_next = '0;
          ovf_next        = 1'b0;
          if (!in_byte[7]) begin
            // Literal: five length bits, then up to three more length bytes.
            len_count_next = FW'(in_byte[4:0]);
            hdr_left_next  = {1'b0, in_byte[6:5]};
            if (in_byte[6:5] != 2'd0) begin
              phase_next = PH_LIT_HDR;
            end else if (in_byte[4:0] != 5'd0) begin
              phase_next = PH_LIT_DATA;
            end else begin
              phase_next = PH_TOKEN;
            end
          end else begin
            hdr_left_next  = in_byte[5:3];
            dist_left_next = in_byte[2:0];
            if (in_byte[5:3] != 3'd0) begin
              phase_next = PH_MATCH_HDR;
            end else if (in_byte[2:0] != 3'd0) begin
              phase_next = PH_MATCH_DIST;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_LIT_HDR: begin
          len_count_next = {len_count[FW-9:0], in_byte};
          hdr_left_next  = hdr_left - 3'd1;
          if (hdr_left == 3'd1) begin
            phase_next = (len_count_next != '0) ? PH_LIT_DATA : PH_TOKEN;
          end
        end
        PH_LIT_DATA: begin
          push_item.byte_valid = 1'b1;
          push_item.out_byte   = in_byte;
          push_item.waddr      = wr_ptr;
          wr_ptr_next = lztsd_pkg::next_index(wr_ptr);
          if (filled != FL'(lztsd_pkg::HISTORY_DEPTH)) begin
            filled_next = filled + FL'(1);
          end
          len_count_next = len_count - FW'(1);
          if (len_count == FW'(1)) begin
            phase_next = PH_TOKEN;
          end
        end
        PH_MATCH_HDR: begin
          len_count_next = {len_count[FW-9:0], in_byte};
          if (len_count[FW-1:FW-8] != 8'd0) begin
            ovf_next = 1'b1;
            err      = lztsd_pkg::ERR_OVERFLOW;
          end
          hdr_left_next = hdr_left - 3'd1;
          if (hdr_left == 3'd1) begin
            if (dist_left != 3'd0) begin
              phase_next = PH_MATCH_DIST;
            end else begin
              finish = 1'b1;
            end
          end
        end
        PH_MATCH_DIST: begin
          dist_value_next = {dist_value[FW-9:0], in_byte};
          if (dist_value[FW-1:FW-8] != 8'd0) begin
            ovf_next = 1'b1;
            err      = lztsd_pkg::ERR_OVERFLOW;
          end
          dist_left_next = dist_left - 3'd1;
          if (dist_left == 3'd1) begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_next = PH_TOKEN;
        end
      endcase

      // All match fields are in: drop it, reject it, or arm the copy.
      if (finish) begin
        // Source of a copy: write pointer minus distance, wrapped into the window.
        dist_lo  = dist_value_next[FL-1:0];
        src_calc = (wp_ext >= dist_lo) ? (wp_ext - dist_lo)
                                       : (wp_ext + FL'(lztsd_pkg::HISTORY_DEPTH) - dist_lo);
        phase_next = PH_TOKEN;
        if (ovf_next || (len_count_next == '0)) begin
          ovf_next       = 1'b0;
          len_count_next = '0;
        end else if ((dist_value_next == '0) || (dist_value_next > FW'(filled))) begin
          len_count_next = '0;
          err            = lztsd_pkg::ERR_DISTANCE;
        end else begin
          copy_src_next = src_calc[lztsd_pkg::HIST_AW-1:0];
          phase_next    = PH_COPY;
        end
      end

      if (in_last) begin
        if (phase_next == PH_COPY) begin
          restart_pend_next = 1'b1;
        end else begin
          if (phase_next != PH_TOKEN) begin
            err = lztsd_pkg::ERR_TRUNCATED;
          end
          phase_next        = PH_TOKEN;
          hdr_left_next     = '0;
          dist_left_next    = '0;
          len_count_next    = '0;
          dist_value_next   = '0;
          wr_ptr_next       = '0;
          filled_next       = '0;
          copy_src_next     = '0;
          ovf_next          = 1'b0;
          restart_pend_next = 1'b0;
        end
      end
    end

    push_item.copy_pending = (phase_next == PH_COPY);
    push_item.error_code   = err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_TOKEN;
      hdr_left     <= '0;
      dist_left    <= '0;
      len_count    <= '0;
      dist_value   <= '0;
      wr_ptr       <= '0;
      filled       <= '0;
      copy_src     <= '0;
      ovf          <= 1'b0;
      restart_pend <= 1'b0;
    end else if (fire) begin
      phase        <= phase_next;
      hdr_left     <= hdr_left_next;
      dist_left    <= dist_left_next;
      len_count    <= len_count_next;
      dist_value   <= dist_value_next;
      wr_ptr       <= wr_ptr_next;
      filled       <= filled_next;
      copy_src     <= copy_src_next;
      ovf          <= ovf_next;
      restart_pend <= restart_pend_next;
    end
  end

  // A copy in progress always has bytes left to pull.
  a_copy_len : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_COPY) |-> (len_count != '0))
    else $error("copy armed with zero length");

  // The deferred restart only exists while a copy is running.
  a_restart_in_copy : assert property (@(posedge clk) disable iff (rst)
    restart_pend |-> (phase == PH_COPY))
    else $error("deferred restart outside a copy");

  // The fill count never passes the window size.
  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    filled <= FL'(lztsd_pkg::HISTORY_DEPTH))
    else $error("history fill count out of range");

endmodule

/* sv/lztsd_queue.sv */
// Short register queue that decouples the token parser from the history back end.
// Depends on lztsd_pkg.
module lztsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lztsd_pkg::item_t push_item,
  output logic             space,
  output logic             head_valid,
  output lztsd_pkg::item_t head_item,
  input  logic             pop
);

  localparam int unsigned QD = lztsd_pkg::QUEUE_DEPTH;
  localparam int unsigned QA = lztsd_pkg::QUEUE_AW;
  localparam int unsigned QC = lztsd_pkg::QUEUE_CW;

  lztsd_pkg::item_t entries [QD];
  logic [QA-1:0]    wr_idx;
  logic [QA-1:0]    rd_idx;
  logic [QC-1:0]    count;

  function automatic logic [QA-1:0] bump(input logic [QA-1:0] i);
    logic [QA-1:0] r;
    if (i == QA'(QD - 1)) begin
      r = '0;
    end else begin
      r = i + QA'(1);
    end
    return r;
  endfunction

  assign space      = (count != QC'(QD));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_idx];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= bump(wr_idx);
      end
      if (pop) begin
        rd_idx <= bump(rd_idx);
      end
      if (push && !pop) begin
        count <= count + QC'(1);
      end else if (pop && !push) begin
        count <= count - QC'(1);
      end
    end
  end

endmodule

/* sv/lztsd_back.sv */
// History back end: reads copy bytes from the history memory, forwards the byte
// still being written, records every output byte and holds the output register.
// Depends on lztsd_pkg.
module lztsd_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  head_valid,
  input  lztsd_pkg::item_t                      head_item,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lztsd_pkg::OUT_TDATA_W-1:0]     out_data
);

  logic [lztsd_pkg::BYTE_W-1:0] hist_mem [lztsd_pkg::HISTORY_DEPTH];

  logic                         b_valid;
  lztsd_pkg::item_t             b_item;
  logic                         b_hit;
  logic [lztsd_pkg::BYTE_W-1:0] b_fwd;
  logic [lztsd_pkg::BYTE_W-1:0] rd_data;
  logic [lztsd_pkg::BYTE_W-1:0] b_data;
  logic                         mem_we;
  logic                         hit_now;

  assign pop = head_valid && (!b_valid || out_ready);

  // Held word writes its byte every cycle it sits here; the rewrite is idempotent.
  assign mem_we = b_valid && b_item.byte_valid;

  // The memory returns old data when the word ahead writes the same address.
  assign hit_now = head_item.is_copy && mem_we && (head_item.raddr == b_item.waddr);

  always_comb begin
    if (b_item.is_copy) begin
      b_data = b_hit ? b_fwd : rd_data;
    end else begin
      b_data = b_item.out_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      hist_mem[b_item.waddr] <= b_data;
    end
    if (pop) begin
      rd_data <= hist_mem[head_item.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= head_item;
      b_hit  <= hit_now;
      b_fwd  <= b_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (pop) begin
      b_valid <= 1'b1;
    end else if (out_ready) begin
      b_valid <= 1'b0;
    end
  end

  assign out_valid = b_valid;
  assign out_data  = {3'b000, b_item.error_code, b_item.copy_pending, b_data,
                      b_item.byte_valid};

  a_copy_has_byte : assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_item.is_copy) |-> b_item.byte_valid)
    else $error("copy word without a byte");

  // A literal byte cut off by the end marker is the only word that carries both.
  a_err_no_byte : assert property (@(posedge clk) disable iff (rst)
    (b_valid && (b_item.error_code != lztsd_pkg::ERR_OK) &&
     (b_item.error_code != lztsd_pkg::ERR_TRUNCATED)) |-> !b_item.byte_valid)
    else $error("error word carries a byte");

  a_hit_copy : assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_hit) |-> b_item.is_copy)
    else $error("forwarding flagged on a non-copy word");

endmodule

/* dv/tb_lz_token_stream_decompressor.sv */
// Self-checking testbench for lz_token_stream_decompressor: a queue-fed stream driver,
// a clocked output monitor and a bit-accurate token decoder that predicts every output word.
// Depends on lztsd_pkg and the decompressor RTL.
module tb_lz_token_stream_decompressor;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 800;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [2:0] {
    WAIT_TOKEN, LIT_LEN, LIT_DATA, MATCH_HDR, MATCH_DIST, COPYING
  } decode_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       eos;
  } cmd_word_t;

  typedef struct packed {
    logic                 valid;
    logic [7:0]           data;
    logic                 pending;
    lztsd_pkg::err_code_t err;
  } out_word_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  logic [lztsd_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                              s_axis_tuser = 1'b0;
  logic                              s_axis_tlast = 1'b0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  logic [lztsd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  cmd_word_t  pending_words[$];
  cmd_word_t  held_word;
  out_word_t  expected_words[$];
  logic [7:0] token_bytes[$];

  int accepted_words = 0;
  int total_words    = 1;
  int gen_count      = 0;
  int stream_len     = 0;   // bytes decoded since the last restart, as the generator sees it
  int failures       = 0;
  int cycle_count    = 0;

  // Decoder model state.
  decode_state_t          dec_state = WAIT_TOKEN;
  logic [2:0]             len_bytes_left = '0;
  logic [2:0]             dist_bytes_left = '0;
  logic [31:0]            run_length = '0;
  logic [31:0]            match_distance = '0;
  logic [7:0]             history [lztsd_pkg::HISTORY_DEPTH];
  lztsd_pkg::hist_addr_t  wr_addr = '0;
  lztsd_pkg::hist_addr_t  copy_addr = '0;
  lztsd_pkg::fill_count_t filled = '0;
  logic                   field_overflowed = 1'b0;
  logic                   end_after_copy = 1'b0;

  lz_token_stream_decompressor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Decoder model
  // ---------------------------------------------------------------------------

  function automatic lztsd_pkg::hist_addr_t step_addr(input lztsd_pkg::hist_addr_t a);
    return lztsd_pkg::hist_addr_t'((int'(a) + 1) % lztsd_pkg::HISTORY_DEPTH);
  endfunction

  // Restart: parser, pointers and fill level go back to zero; history bytes stay.
  function automatic void clear_stream();
    dec_state        = WAIT_TOKEN;
    len_bytes_left   = '0;
    dist_bytes_left  = '0;
    run_length       = '0;
    match_distance   = '0;
    wr_addr          = '0;
    filled           = '0;
    copy_addr        = '0;
    field_overflowed = 1'b0;
    end_after_copy   = 1'b0;
  endfunction

  function automatic void store_byte(input logic [7:0] b);
    history[wr_addr] = b;
    wr_addr = step_addr(wr_addr);
    if (filled < lztsd_pkg::HISTORY_DEPTH) filled = filled + 1'b1;
  endfunction

  // All match fields are in: drop, reject or arm the copy.
  function automatic lztsd_pkg::err_code_t close_match();
    dec_state = WAIT_TOKEN;
    if (field_overflowed || run_length == 0) begin
      field_overflowed = 1'b0;
      run_length = '0;
      return lztsd_pkg::ERR_OK;
    end
    if (match_distance == 0 || match_distance > filled) begin
      run_length = '0;
      return lztsd_pkg::ERR_DISTANCE;
    end
    copy_addr = lztsd_pkg::hist_addr_t'((longint'(wr_addr)
                  + longint'(lztsd_pkg::HISTORY_DEPTH) - longint'(match_distance))
                  % longint'(lztsd_pkg::HISTORY_DEPTH));
    dec_state = COPYING;
    return lztsd_pkg::ERR_OK;
  endfunction

  // Works out the output word for one accepted input word.
  function automatic void decode_word(input cmd_word_t w);
    out_word_t r;
    lztsd_pkg::err_code_t e;
    r = '0;
    e = lztsd_pkg::ERR_OK;
    if (w.cmd == lztsd_pkg::CMD_PULL) begin
      if (dec_state != COPYING) begin
        e = lztsd_pkg::ERR_EMPTY_PULL;
      end else begin
        r.valid = 1'b1;
        r.data  = history[copy_addr];
        store_byte(r.data);
        copy_addr  = step_addr(copy_addr);
        run_length = run_length - 1;
        if (run_length == 0) begin
          dec_state = WAIT_TOKEN;
          if (end_after_copy) clear_stream();
        end
      end
    end else if (dec_state == COPYING) begin
      // A push while a copy is pending is dropped whole, end marker included.
      e = lztsd_pkg::ERR_PUSH_BUSY;
    end else begin
      case (dec_state)
        WAIT_TOKEN: begin
          run_length       = '0;
          match_distance   = '0;
          field_overflowed = 1'b0;
          if (!w.data[7]) begin
            run_length     = 32'(w.data[4:0]);
            len_bytes_left = {1'b0, w.data[6:5]};
            if (len_bytes_left != 0) dec_state = LIT_LEN;
            else dec_state = (run_length != 0) ? LIT_DATA : WAIT_TOKEN;
          end else begin
            len_bytes_left  = w.data[5:3];
            dist_bytes_left = w.data[2:0];
            if (len_bytes_left != 0) dec_state = MATCH_HDR;
            else if (dist_bytes_left != 0) dec_state = MATCH_DIST;
            else e = close_match();
          end
        end
        LIT_LEN: begin
          run_length = {run_length[23:0], w.data};
          len_bytes_left = len_bytes_left - 1'b1;
          if (len_bytes_left == 0) dec_state = (run_length != 0) ? LIT_DATA : WAIT_TOKEN;
        end
        LIT_DATA: begin
          r.valid = 1'b1;
          r.data  = w.data;
          store_byte(w.data);
          run_length = run_length - 1;
          if (run_length == 0) dec_state = WAIT_TOKEN;
        end
        MATCH_HDR: begin
          if (run_length[31:24] != 0) begin
            field_overflowed = 1'b1;
            e = lztsd_pkg::ERR_OVERFLOW;
          end
          run_length = {run_length[23:0], w.data};
          len_bytes_left = len_bytes_left - 1'b1;
          if (len_bytes_left == 0) begin
            if (dist_bytes_left != 0) dec_state = MATCH_DIST;
            else if (close_match() == lztsd_pkg::ERR_DISTANCE) e = lztsd_pkg::ERR_DISTANCE;
          end
        end
        default: begin
          if (match_distance[31:24] != 0) begin
            field_overflowed = 1'b1;
            e = lztsd_pkg::ERR_OVERFLOW;
          end
          match_distance = {match_distance[23:0], w.data};
          dist_bytes_left = dist_bytes_left - 1'b1;
          if (dist_bytes_left == 0 && close_match() == lztsd_pkg::ERR_DISTANCE)
            e = lztsd_pkg::ERR_DISTANCE;
        end
      endcase
      // The end marker restarts at once, or after the copy it just armed.
      if (w.eos) begin
        if (dec_state == COPYING) begin
          end_after_copy = 1'b1;
        end else begin
          if (dec_state != WAIT_TOKEN) e = lztsd_pkg::ERR_TRUNCATED;
          clear_stream();
        end
      end
    end
    r.pending = (dec_state == COPYING);
    r.err     = e;
    expected_words.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus generation
  // ---------------------------------------------------------------------------

  // Words that the block ignores are queued with counts = 0.
  function automatic void queue_word(input logic cmd, input logic [7:0] b, input logic eos,
                                     input bit counts);
    cmd_word_t w;
    w.cmd  = cmd;
    w.data = b;
    w.eos  = eos;
    pending_words.push_back(w);
    if (counts) gen_count++;
  endfunction

  // Sends the first count bytes of the staged token, the end marker on the last one.
  function automatic void send_token(input int count, input bit eos);
    for (int i = 0; i < count; i++) begin
      queue_word(lztsd_pkg::CMD_PUSH, token_bytes.pop_front(), eos && i == count - 1, 1'b1);
    end
    token_bytes.delete();
  endfunction

  // Big-endian field of n bytes; bytes above bit 31 come out as leading zeros.
  function automatic void put_field(input int unsigned value, input int n);
    for (int i = n - 1; i >= 0; i--) token_bytes.push_back(8'(value >> (8 * i)));
  endfunction

  function automatic int min_bytes(input int unsigned v);
    if (v < 32'h100) return 1;
    if (v < 32'h1_0000) return 2;
    if (v < 32'h100_0000) return 3;
    return 4;
  endfunction

  // Now and then widen a field with leading zero bytes, up to seven bytes.
  function automatic int pad_bytes(input int need);
    return need + (($urandom_range(3) == 0) ? $urandom_range(7 - need, 0) : 0);
  endfunction

  function automatic void stage_match(input int unsigned len, input int nl,
                                      input int unsigned back_dist, input int nd);
    token_bytes.delete();
    token_bytes.push_back({1'b1, 1'($urandom), 3'(nl), 3'(nd)});
    put_field(len, nl);
    put_field(back_dist, nd);
  endfunction

  function automatic void grow_stream(input int len);
    stream_len = (stream_len + len > lztsd_pkg::HISTORY_DEPTH) ? lztsd_pkg::HISTORY_DEPTH
                                                               : stream_len + len;
  endfunction

  // Mostly well-formed literals and matches with their pulls; the rest is bad
  // matches, empty pulls, truncated tokens and clean stream ends.
  function automatic void build_random(input int target);
    int r, len, back_dist, lim, nl, nd, nx, k;
    bit eos;
    logic [7:0] tok;
    while (gen_count < target) begin
      r = $urandom_range(99);
      if (r >= 35 && r < 70 && stream_len == 0) r = 0;
      if (r < 35) begin
        nx  = $urandom_range(3);
        len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(12);
        eos = ($urandom_range(11) == 0);
        token_bytes.delete();
        if (nx == 0) begin
          if (len > 31) len = 31;
          token_bytes.push_back({3'b000, 5'(len)});
        end else begin
          token_bytes.push_back({1'b0, 2'(nx), 5'b0});
          put_field(len, nx);
        end
        for (k = 0; k < len; k++) token_bytes.push_back(8'($urandom));
        send_token(token_bytes.size(), eos);
        if (eos) stream_len = 0;
        else grow_stream(len);
      end else if (r < 70) begin
        len  = ($urandom_range(4) == 0) ? $urandom_range(60, 1) : $urandom_range(12, 1);
        lim  = (stream_len > 65535) ? 65535 : stream_len;
        back_dist = $urandom_range(1) ? $urandom_range((lim < 8) ? lim : 8, 1)
                                      : $urandom_range(lim, 1);
        eos  = ($urandom_range(9) == 0);
        stage_match(len, pad_bytes(min_bytes(len)), back_dist,
                    pad_bytes(min_bytes(back_dist)));
        send_token(token_bytes.size(), eos);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(15) == 0)
            queue_word(lztsd_pkg::CMD_PUSH, 8'($urandom), 1'($urandom), 1'b0);
          queue_word(lztsd_pkg::CMD_PULL, 8'($urandom), 1'($urandom), 1'b1);
        end
        if (eos) stream_len = 0;
        else grow_stream(len);
      end else if (r < 82) begin
        eos = ($urandom_range(5) == 0);
        len = $urandom_range(12, 1);
        case ($urandom_range(3))
          0: stage_match(len, pad_bytes(1), 0, $urandom_range(3));
          1: begin
            back_dist = stream_len + $urandom_range(300, 1);
            stage_match(len, pad_bytes(1), back_dist, pad_bytes(min_bytes(back_dist)));
          end
          2: stage_match(0, $urandom_range(7), $urandom, $urandom_range(3));
          default: begin
            // A field of five or more bytes led by a nonzero byte overflows.
            nl = $urandom_range(7, 5);
            nd = $urandom_range(3);
            if ($urandom_range(1)) begin
              k  = nl;
              nl = nd;
              nd = k;
            end
            token_bytes.delete();
            token_bytes.push_back({1'b1, 1'($urandom), 3'(nl), 3'(nd)});
            for (k = 0; k < nl + nd; k++) begin
              if ((k == 0 && nl >= 5) || (k == nl && nd >= 5))
                token_bytes.push_back(8'($urandom_range(255, 1)));
              else
                token_bytes.push_back(8'($urandom));
            end
          end
        endcase
        send_token(token_bytes.size(), eos);
        if (eos) stream_len = 0;
      end else if (r < 90) begin
        queue_word(lztsd_pkg::CMD_PULL, 8'($urandom), 1'($urandom), 1'b1);
      end else if (r < 97) begin
        // The end marker lands inside a token that still wants bytes.
        token_bytes.delete();
        if ($urandom_range(1)) begin
          tok = {1'b1, 7'($urandom)};
          if (tok[5:0] == 0) tok[0] = 1'b1;
          nl = int'(tok[5:3]) + int'(tok[2:0]);
          token_bytes.push_back(tok);
          for (k = 0; k < nl; k++) token_bytes.push_back(8'($urandom));
          send_token($urandom_range(token_bytes.size() - 1, 1), 1'b1);
        end else begin
          nx  = $urandom_range(3);
          tok = {1'b0, 2'(nx), 5'($urandom_range(31, 1))};
          token_bytes.push_back(tok);
          // The last length byte keeps the length above the data bytes sent below.
          for (k = 0; k < nx; k++)
            token_bytes.push_back((k == nx - 1) ? (8'($urandom) | 8'h04) : 8'($urandom));
          len = (nx == 0) ? int'(tok[4:0]) - 1 : 3;
          if (len > 3) len = 3;
          nd = $urandom_range(len, 0);
          for (k = 0; k < nd; k++) token_bytes.push_back(8'($urandom));
          send_token($urandom_range(token_bytes.size(), 1), 1'b1);
        end
        stream_len = 0;
      end else begin
        queue_word(lztsd_pkg::CMD_PUSH, 8'h00, 1'b1, 1'b1);
        stream_len = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Pacing: sender idles 12% / receiver 82%, then the reverse, then no idling.
  // ---------------------------------------------------------------------------

  function automatic int pace_phase();
    return (accepted_words * 3) / total_words;
  endfunction

  function automatic int sender_idle_pct();
    case (pace_phase())
      0: return 12;
      1: return 82;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case (pace_phase())
      0: return 82;
      1: return 12;
      default: return 0;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: a word stays on the bus until taken; the model sees it on acceptance.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
      s_axis_tlast  <= 1'b0;
      clear_stream();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_word(held_word);
        accepted_words++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
          held_word = pending_words.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= held_word.data;
          s_axis_tuser  <= held_word.cmd;
          s_axis_tlast  <= held_word.eos;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted output word is matched against the oldest prediction.
  // ---------------------------------------------------------------------------

  function automatic void check_word(input logic [lztsd_pkg::OUT_TDATA_W-1:0] t);
    out_word_t x;
    if (expected_words.size() == 0) begin
      $error("unexpected output word %h", t);
      failures++;
    end else begin
      x = expected_words.pop_front();
      if (t[0] !== x.valid) begin
        $error("byte_valid: expected %0d, got %0d", x.valid, t[0]);
        failures++;
      end
      if (t[8:1] !== x.data) begin
        $error("out_byte: expected %h, got %h", x.data, t[8:1]);
        failures++;
      end
      if (t[9] !== x.pending) begin
        $error("copy_pending: expected %0d, got %0d", x.pending, t[9]);
        failures++;
      end
      if (t[12:10] !== x.err) begin
        $error("error_code: expected %0d, got %0d", x.err, t[12:10]);
        failures++;
      end
      if (t[15:13] !== 3'b000) begin
        $error("pad: expected 0, got %0d", t[15:13]);
        failures++;
      end
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Directed opening: empty pull, literal extremes, zero-length literal, a
    // short copy with a push during it, distance zero, a length field overflow,
    // an end marker on the byte that arms a copy, and a truncated literal.
    queue_word(lztsd_pkg::CMD_PULL, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h02, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'hff, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h89, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h02, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h02, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PULL, 8'hff, 1'b1, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h55, 1'b1, 1'b0);
    queue_word(lztsd_pkg::CMD_PULL, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h88, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h04, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'ha8, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h01, 1'b0, 1'b1);
    repeat (4) queue_word(lztsd_pkg::CMD_PUSH, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h89, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h01, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h01, 1'b1, 1'b1);
    queue_word(lztsd_pkg::CMD_PULL, 8'h00, 1'b0, 1'b1);
    queue_word(lztsd_pkg::CMD_PUSH, 8'h05, 1'b1, 1'b1);
    stream_len = 0;

    build_random(gen_count + RANDOM_WORDS);
    total_words = pending_words.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain: everything sent, everything predicted has come back.
    while (pending_words.size() != 0 || s_axis_tvalid || expected_words.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/lztsd_pkg.sv
sv/lztsd_front.sv
sv/lztsd_queue.sv
sv/lztsd_back.sv
sv/lz_token_stream_decompressor.sv
dv/tb_lz_token_stream_decompressor.sv
